// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sine/cosine generator.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: rtl/dpsc_pkg.sv
// Package of the degree-phase sine/cosine generator: widths, phase and CORDIC
// constants, arctangent table, sequencer and register types. No dependencies.
package dpsc_pkg;

    localparam int CORDIC_STEPS        = 16;
    localparam int PHASE_FRACTION_BITS = 16;

    localparam int PHASE_W  = 25;
    localparam int STEP_W   = 26;
    localparam int AMP_W    = 16;
    localparam int SAMPLE_W = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // CORDIC datapath, Q30 with headroom
    localparam int CW     = 33;
    localparam int Q_FRAC = 30;
    localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam int MUL_A_W = CW;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [PHASE_W-1:0] FULL_TURN    = PHASE_W'(360 << PHASE_FRACTION_BITS);
    localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(90 << PHASE_FRACTION_BITS);
    localparam logic [PHASE_W-1:0] HALF_TURN    = PHASE_W'(180 << PHASE_FRACTION_BITS);
    localparam logic [PHASE_W-1:0] THREE_QUARTER_TURN = PHASE_W'(270 << PHASE_FRACTION_BITS);

    // degrees to radians, Q40: floor(floor(pi * 2^60) / 2^20 / 180)
    localparam int DEG2RAD_W    = 35;
    localparam int DEG2RAD_LO_W = 18;
    localparam logic [DEG2RAD_W-1:0] DEG2RAD = 35'd19190098068;
    localparam logic [DEG2RAD_LO_W-1:0] DEG2RAD_LO = DEG2RAD[DEG2RAD_LO_W-1:0];
    localparam logic [DEG2RAD_W-DEG2RAD_LO_W-1:0] DEG2RAD_HI = DEG2RAD[DEG2RAD_W-1:DEG2RAD_LO_W];
    localparam int RAD_SHIFT = 10 + PHASE_FRACTION_BITS;
    localparam int RAD_SUM_W = PHASE_W + DEG2RAD_W;

    localparam logic signed [CW-1:0] GAIN_Q30 = CW'(32'h26DD3B6A);

    // atan(2^-i) in Q30, rounded half up
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_AW    = 5;
    localparam logic [31:0] ATAN_TABLE [ATAN_DEPTH] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    localparam int SAMPLE_MAX = 32767;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RAD,
        ST_ROT,
        ST_SEL,
        ST_SCALE
    } state_t;

    typedef enum logic [1:0] {
        REG_WAVEFORM,
        REG_AMPLITUDE,
        REG_START_ANGLE,
        REG_PHASE_STEP
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic step;
    } cordic_ctrl_t;

endpackage

// File: rtl/dpsc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on dpsc_pkg for operand widths.
module dpsc_mul (
    input  logic                                 clk,
    input  logic signed [dpsc_pkg::MUL_A_W-1:0]  a,
    input  logic signed [dpsc_pkg::MUL_B_W-1:0]  b,
    output logic signed [dpsc_pkg::MUL_P_W-1:0]  prod
);
    import dpsc_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/dpsc_cordic.sv
// Iterative CORDIC rotation engine: one add/shift micro-rotation per cycle while ctrl.step is high.
// Depends on dpsc_pkg for widths, gain and arctangent table.
module dpsc_cordic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dpsc_pkg::cordic_ctrl_t           ctrl,
    input  logic signed [dpsc_pkg::CW-1:0]   z_init,
    output logic signed [dpsc_pkg::CW-1:0]   x,
    output logic signed [dpsc_pkg::CW-1:0]   y,
    output logic                             last
);
    import dpsc_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] dx, dy, angle;
    logic [ITER_W-1:0]    iter_reg;

    assign dx    = y_reg >>> iter_reg;
    assign dy    = x_reg >>> iter_reg;
    assign angle = CW'(ATAN_TABLE[ATAN_AW'(iter_reg)]);

    always_comb
    begin
        if (!z_reg[CW-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - angle;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= '0;
        else if (ctrl.load)
            iter_reg <= '0;
        else if (ctrl.step)
            iter_reg <= iter_reg + ITER_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= GAIN_Q30;
            y_reg <= '0;
            z_reg <= z_init;
        end
        else if (ctrl.step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign last = (iter_reg == ITER_W'(CORDIC_STEPS - 1));

endmodule

// File: rtl/degree_phase_sine_cosine_generator.sv
// An accepted input word runs through the states FOLD, MUL_LO, MUL_HI, RAD, ROT, SEL and SCALE;
// the ROT state runs the CORDIC loop, one micro-rotation a cycle on the shared add/shift unit.
// The input stalls while a word is in work; a finished word waits in the output register.
// Reset (rst_n, async, active low): configuration registers to their reset values, phase 0, output empty.
module degree_phase_sine_cosine_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dpsc_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dpsc_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [15:0] sample, [40:16] phase_used
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dpsc_pkg::PADDR_W-1:0]      paddr,
    input  logic [dpsc_pkg::PDATA_W-1:0]      pwdata,
    output logic [dpsc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import dpsc_pkg::*;
    `include "assert_macros.svh"

    localparam logic signed [MUL_P_W-1:0] TRUNC_BIAS = (MUL_P_W'(1) <<< Q_FRAC) - MUL_P_W'(1);
    localparam logic signed [MUL_P_W-1:0] SAT_HI     = MUL_P_W'(SAMPLE_MAX);
    localparam logic signed [MUL_P_W-1:0] SAT_LO     = -SAT_HI;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = -SAMPLE_W'(SAMPLE_MAX);
    localparam logic signed [STEP_W+1:0]  FULL_S     = $signed((STEP_W+2)'(FULL_TURN));

    // configuration
    logic                      waveform_reg;
    logic signed [AMP_W-1:0]   amplitude_reg;
    logic [PHASE_W-1:0]        start_angle_reg;
    logic signed [STEP_W-1:0]  phase_step_reg;
    logic                      cfg_wr;
    reg_idx_t                  cfg_idx;

    // sequencer and datapath
    state_t                    state_reg, state_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic [PHASE_W-1:0]        p_reg, r_reg, step_mod_reg;
    logic [1:0]                q_reg;
    logic [MUL_P_W-1:0]        lo_prod_reg;
    logic                      out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [PHASE_W-1:0]        out_phase_reg;

    logic                      accept, out_load;
    logic [PHASE_W-1:0]        start_mod, fold_r;
    logic [1:0]                fold_q, quad;
    logic signed [STEP_W+1:0]  step_ext, step_wrap;
    logic [PHASE_W:0]          phase_sum;
    logic [RAD_SUM_W-1:0]      rad_sum;
    logic signed [CW-1:0]      z_init, cx, cy, u_sel;
    logic                      cordic_last;
    cordic_ctrl_t              cordic_ctrl;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod, prod_bias, scaled;
    logic signed [SAMPLE_W-1:0] sample_sat;

    dpsc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    dpsc_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cordic_ctrl),
        .z_init (z_init),
        .x      (cx),
        .y      (cy),
        .last   (cordic_last)
    );

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg    <= 1'b0;
            amplitude_reg   <= AMP_W'(SAMPLE_MAX);
            start_angle_reg <= '0;
            phase_step_reg  <= STEP_W'(1 << PHASE_FRACTION_BITS);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WAVEFORM:    waveform_reg    <= pwdata[0];
                REG_AMPLITUDE:   amplitude_reg   <= pwdata[AMP_W-1:0];
                REG_START_ANGLE: start_angle_reg <= pwdata[PHASE_W-1:0];
                REG_PHASE_STEP:  phase_step_reg  <= pwdata[STEP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WAVEFORM:    prdata = PDATA_W'(waveform_reg);
            REG_AMPLITUDE:   prdata = PDATA_W'($unsigned(amplitude_reg));
            REG_START_ANGLE: prdata = PDATA_W'(start_angle_reg);
            REG_PHASE_STEP:  prdata = PDATA_W'($unsigned(phase_step_reg));
        endcase
    end

    // phase arithmetic
    assign accept    = s_axis_tvalid & s_axis_tready;
    assign start_mod = (start_angle_reg >= FULL_TURN) ? (start_angle_reg - FULL_TURN)
                                                      : start_angle_reg;

    always_comb
    begin
        priority if (p_reg >= THREE_QUARTER_TURN)
        begin
            fold_q = 2'd3;
            fold_r = p_reg - THREE_QUARTER_TURN;
        end
        else if (p_reg >= HALF_TURN)
        begin
            fold_q = 2'd2;
            fold_r = p_reg - HALF_TURN;
        end
        else if (p_reg >= QUARTER_TURN)
        begin
            fold_q = 2'd1;
            fold_r = p_reg - QUARTER_TURN;
        end
        else
        begin
            fold_q = 2'd0;
            fold_r = p_reg;
        end
    end

    assign step_ext = (STEP_W+2)'(phase_step_reg);

    always_comb
    begin
        priority if (step_ext < -FULL_S)
            step_wrap = step_ext + FULL_S + FULL_S;
        else if (step_ext < 0)
            step_wrap = step_ext + FULL_S;
        else if (step_ext >= FULL_S)
            step_wrap = step_ext - FULL_S;
        else
            step_wrap = step_ext;
    end

    assign phase_sum  = {1'b0, p_reg} + {1'b0, step_mod_reg};
    assign phase_next = (phase_sum >= {1'b0, FULL_TURN}) ? PHASE_W'(phase_sum - {1'b0, FULL_TURN})
                                                         : phase_sum[PHASE_W-1:0];

    // radians: low and high partial products of r * DEG2RAD
    assign rad_sum = RAD_SUM_W'(lo_prod_reg)
                   + (RAD_SUM_W'($unsigned(mul_prod)) << DEG2RAD_LO_W);
    assign z_init  = CW'(rad_sum >> RAD_SHIFT);

    // quadrant unfold
    assign quad = q_reg + {1'b0, waveform_reg};

    always_comb
    begin
        unique case (quad)
            2'd0: u_sel = cy;
            2'd1: u_sel = cx;
            2'd2: u_sel = -cy;
            2'd3: u_sel = -cx;
        endcase
    end

    // scale, truncate toward zero, saturate
    assign prod_bias = mul_prod + (mul_prod[MUL_P_W-1] ? TRUNC_BIAS : MUL_P_W'(0));
    assign scaled    = prod_bias >>> Q_FRAC;

    always_comb
    begin
        priority if (scaled > SAT_HI)
            sample_sat = SAMPLE_W'(SAMPLE_MAX);
        else if (scaled < SAT_LO)
            sample_sat = SAMPLE_LO;
        else
            sample_sat = scaled[SAMPLE_W-1:0];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cordic_ctrl   = '0;
        mul_a         = '0;
        mul_b         = '0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
                state_next = ST_MUL_LO;
            ST_MUL_LO:
            begin
                mul_a      = MUL_A_W'(r_reg);
                mul_b      = MUL_B_W'(DEG2RAD_LO);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                mul_a      = MUL_A_W'(r_reg);
                mul_b      = MUL_B_W'(DEG2RAD_HI);
                state_next = ST_RAD;
            end
            ST_RAD:
            begin
                cordic_ctrl.load = 1'b1;
                state_next       = ST_ROT;
            end
            ST_ROT:
            begin
                cordic_ctrl.step = 1'b1;
                if (cordic_last)
                    state_next = ST_SEL;
            end
            ST_SEL:
            begin
                mul_a      = u_sel;
                mul_b      = MUL_B_W'(amplitude_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // operands held so the product survives an output stall
                mul_a = u_sel;
                mul_b = MUL_B_W'(amplitude_reg);
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_MUL_LO)
                phase_reg <= phase_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            p_reg <= s_axis_tdata[0] ? start_mod : phase_reg;
        if (state_reg == ST_FOLD)
        begin
            q_reg        <= fold_q;
            r_reg        <= fold_r;
            step_mod_reg <= PHASE_W'(step_wrap);
        end
        if (state_reg == ST_MUL_HI)
            lo_prod_reg <= $unsigned(mul_prod);
        if (out_load)
        begin
            out_sample_reg <= sample_sat;
            out_phase_reg  <= p_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_phase_reg, out_sample_reg});

    `ASSERT_NEVER(a_phase_range, clk, rst_n, phase_reg >= FULL_TURN, "phase left [0, 360)")
    `ASSERT_PROP(a_fold_range, clk, rst_n, (state_reg == ST_MUL_LO) |-> (r_reg < QUARTER_TURN), "fold remainder beyond a quarter turn")
    `ASSERT_PROP(a_accept_fold, clk, rst_n, accept |=> (state_reg == ST_FOLD), "accepted word did not start")
    `ASSERT_PROP(a_rot_done, clk, rst_n, (state_reg == ST_ROT && cordic_last) |=> (state_reg == ST_SEL), "rotation loop overran")
    `ASSERT_PROP(a_sample_sat, clk, rst_n, m_axis_tvalid |-> (out_sample_reg >= SAMPLE_LO), "sample below saturation bound")

endmodule
